### rtl/varc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varc_pkg
// Shared types and constants for the offset base-128 varint codec.
// ----------------------------------------------------------------------------
package varc_pkg;

  localparam int VALUE_BITS = 64;
  localparam int GROUP_BITS = 7;
  localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int CNT_W      = $clog2(MAX_GROUPS + 1);

  localparam logic [63:0] VALUE_MAX   = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [63:0] SHIFT_LIMIT = VALUE_MAX >> GROUP_BITS;
  localparam logic [63:0] GROUP_MAX   = 64'h7F;
  localparam logic [7:0]  CONT_BIT    = 8'h80;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic enc_load;   // take a new value to split
    logic split;      // peel one group onto the stack
    logic pop;        // move top of stack into the output register
    logic dec_load;   // take one byte into the accumulator
  } varc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic split_done; // current split step is the final one
    logic pop_last;   // one byte left on the stack
    logic out_free;   // output register can take a beat this cycle
  } varc_status_t;

endpackage

### rtl/varc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varc_dp
// Datapath: group splitter with byte stack, decode accumulator, output reg.
// ----------------------------------------------------------------------------
module varc_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  varc_pkg::varc_cmd_t   cmd,
  output varc_pkg::varc_status_t status,
  input  logic [63:0]           in_enc_value,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte,
  output logic [63:0]           out_dec_value,
  output logic                  out_last
);
  import varc_pkg::*;

  logic [63:0]      n_r, n_nxt;
  logic [7:0]       stack_r   [MAX_GROUPS];
  logic [7:0]       stack_nxt [MAX_GROUPS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      acc_r, acc_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [63:0]      val_r, val_nxt;
  logic             last_r, last_nxt;

  logic [7:0]       group;
  logic [63:0]      shifted;
  logic             acc_over;

  assign status.out_free   = !out_valid_r || !out_stall;
  assign status.split_done = (n_r <= GROUP_MAX) ||
                             (cnt_r == CNT_W'(MAX_GROUPS - 1));
  assign status.pop_last   = (cnt_r == CNT_W'(1));

  // first group peeled is the final byte and carries no continuation bit
  assign group    = {1'b0, n_r[6:0]} | ((cnt_r == '0) ? 8'h00 : CONT_BIT);
  assign shifted  = ({acc_r[63-GROUP_BITS:0], in_byte[6:0]}) & VALUE_MAX;
  assign acc_over = acc_r > SHIFT_LIMIT;

  always_comb begin
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      stack_nxt[i] = stack_r[i];
    end

    if (cmd.enc_load) begin
      n_nxt   = in_enc_value & VALUE_MAX;
      cnt_nxt = '0;
    end

    if (cmd.split) begin
      stack_nxt[0] = group;
      for (int i = 1; i < MAX_GROUPS; i++) begin
        stack_nxt[i] = stack_r[i-1];
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      n_nxt   = (n_r >> GROUP_BITS) - 64'd1;
    end

    if (cmd.pop) begin
      for (int i = 0; i < MAX_GROUPS - 1; i++) begin
        stack_nxt[i] = stack_r[i+1];
      end
      cnt_nxt       = cnt_r - CNT_W'(1);
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_BYTE;
      byte_nxt      = stack_r[0];
      val_nxt       = '0;
      last_nxt      = (cnt_r == CNT_W'(1));
    end

    if (cmd.dec_load) begin
      byte_nxt = '0;
      val_nxt  = '0;
      last_nxt = 1'b1;
      kind_nxt = KIND_ERROR;
      if (acc_over) begin
        // shift would drop set bits: error, byte discarded
        acc_nxt       = '0;
        out_valid_nxt = 1'b1;
      end else if (in_byte[7]) begin
        if (shifted == VALUE_MAX) begin
          acc_nxt       = '0;
          out_valid_nxt = 1'b1;
        end else begin
          acc_nxt = shifted + 64'd1;
        end
      end else begin
        acc_nxt       = '0;
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_VALUE;
        val_nxt       = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      stack_r[i] <= stack_nxt[i];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_byte      = byte_r;
  assign out_dec_value = val_r;
  assign out_last      = last_r;

endmodule

### rtl/varc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varc_ctrl
// Controller: input handshake and the split / emit sequence of an encode.
// ----------------------------------------------------------------------------
module varc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  varc_pkg::varc_status_t status,
  output varc_pkg::varc_cmd_t    cmd
);
  import varc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SPLIT = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = !((state_r == ST_IDLE) && status.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (command_t'(in_command) == CMD_ENCODE) begin
            cmd.enc_load = 1'b1;
            state_nxt    = ST_SPLIT;
          end else begin
            cmd.dec_load = 1'b1;
          end
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        if (status.split_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.pop = 1'b1;
          if (status.pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/varint_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_codec_core
// Offset base-128 varint encoder / decoder.
// ----------------------------------------------------------------------------
// Input channel (in_*): in_command selects encode of in_enc_value or decode
// of in_byte. Result channel (out_*): out_kind tags each beat as an encoded
// byte, a decoded value or a decode overflow error; out_last marks the final
// beat caused by one input beat. Both channels use valid / stall.
// Decode: one byte per cycle unless in_stall holds the input side; a final
// byte or an error gives its result in the cycle after the input beat, a
// continuation byte gives nothing. Encode of a value with G groups (1..10):
// after the accept cycle, ST_SPLIT peels the groups onto a byte stack, then
// ST_EMIT emits them most significant group first; the input side is
// stalled during that sequence.
// A single output register sits between the sides: a new beat is taken
// whenever that register is empty or being drained in the same cycle.
// A receiver stall holds the output beat and, through it, the input side.
// Reset clears the decode accumulator, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module varint_codec_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_enc_value,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [63:0] out_dec_value,
  output logic        out_last
);
  import varc_pkg::*;

  varc_cmd_t    cmd;
  varc_status_t status;

  varc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .status     (status),
    .cmd        (cmd)
  );

  varc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_enc_value  (in_enc_value),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .out_dec_value (out_dec_value),
    .out_last      (out_last)
  );

endmodule
